// File: rtl/sdz_pkg.sv
// shared types and constants for the stick dead zone and button edge block
// no dependencies; imported by every module of the block
package sdz_pkg;

   localparam int unsigned ITERS = 16;
   localparam int unsigned CNT_W = $clog2(ITERS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ITERS - 1);

   localparam int unsigned AXIS_W = 16;
   localparam int unsigned SQ_W = 32;
   localparam int unsigned DZ_W = 15;

   localparam logic [DZ_W-1:0] FULL_SCALE = 15'h7fff;
   localparam logic [DZ_W-1:0] DZ_RESET = 15'd7849;
   localparam logic [AXIS_W-1:0] MAG_MAX = 16'd46341;
   localparam logic [AXIS_W-1:0] Q_MAX = 16'h8000;

   localparam int unsigned CSR_AW = 3;
   localparam int unsigned CSR_DW = 32;
   localparam logic [CSR_AW-3:0] REG_DEAD_ZONE = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_ROOT,
      ST_DIV_INIT,
      ST_DIV_STEP,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      DIV_X,
      DIV_Y,
      DIV_N
   } div_sel_type;

   typedef struct packed {
      logic accept;
      logic sq_x;
      logic sq_y;
      logic root_step;
      logic div_init;
      logic div_step;
      logic div_last;
      logic finish;
      div_sel_type sel;
      logic [CNT_W-1:0] cnt;
   } ctrl_type;

endpackage

// File: rtl/sdz_req_if.sv
// input channel carrying one polled pad sample per word
// depends on sdz_pkg for field widths
interface sdz_req_if
   import sdz_pkg::*;
();
   logic valid;
   logic ready;
   logic connected;
   logic [AXIS_W-1:0] buttons;
   logic signed [AXIS_W-1:0] stick_x;
   logic signed [AXIS_W-1:0] stick_y;
   logic [AXIS_W-1:0] button_mask;

   modport source (output valid, connected, buttons, stick_x, stick_y, button_mask,
                   input ready);
   modport sink (input valid, connected, buttons, stick_x, stick_y, button_mask,
                 output ready);
endinterface

// File: rtl/sdz_rsp_if.sv
// result channel carrying direction, magnitude and button flags per word
// depends on sdz_pkg for field widths
interface sdz_rsp_if
   import sdz_pkg::*;
();
   logic valid;
   logic ready;
   logic signed [AXIS_W-1:0] dir_x;
   logic signed [AXIS_W-1:0] dir_y;
   logic [AXIS_W-1:0] magnitude_norm;
   logic is_down;
   logic pressed;
   logic released;

   modport source (output valid, dir_x, dir_y, magnitude_norm, is_down, pressed, released,
                   input ready);
   modport sink (input valid, dir_x, dir_y, magnitude_norm, is_down, pressed, released,
                 output ready);
endinterface

// File: rtl/sdz_csr.sv
// apb register file holding the dead zone radius
// depends on sdz_pkg
module sdz_csr
   import sdz_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic pready,
   output logic [DZ_W-1:0] dead_zone
);
   logic [DZ_W-1:0] dz_ff;
   logic [DZ_W-1:0] dz_in;
   logic wr_hit;

   assign pready = 1'b1;
   assign wr_hit = psel && penable && pwrite && (paddr[CSR_AW-1:2] == REG_DEAD_ZONE);
   assign dz_in = wr_hit ? pwdata[DZ_W-1:0] : dz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dz_ff <= DZ_RESET;
      end else begin
         dz_ff <= dz_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[CSR_AW-1:2] == REG_DEAD_ZONE) begin
         prdata = {{(CSR_DW-DZ_W){1'b0}}, dz_ff};
      end
   end

   assign dead_zone = dz_ff;
endmodule

// File: rtl/sdz_trial_sub.sv
// shared trial subtractor used by the root and divide steps
// depends on sdz_pkg
module sdz_trial_sub
   import sdz_pkg::*;
(
   input  logic [SQ_W-1:0] op_a,
   input  logic [SQ_W-1:0] op_b,
   output logic ge,
   output logic [SQ_W-1:0] diff
);
   logic [SQ_W:0] diff_w;

   assign diff_w = {1'b0, op_a} - {1'b0, op_b};
   assign ge = ~diff_w[SQ_W];
   assign diff = diff_w[SQ_W-1:0];
endmodule

// File: rtl/sdz_ctrl.sv
// sequencer: squares, sixteen root steps, then three sixteen-step divides
// depends on sdz_pkg
module sdz_ctrl
   import sdz_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_connected,
   input  logic rsp_free,
   output logic req_ready,
   output ctrl_type ctrl
);
   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   div_sel_type sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         sel_ff <= DIV_X;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         sel_ff <= sel_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      cnt_in = '0;
      sel_in = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = req_connected ? ST_SQ_X : ST_FINISH;
            end
         end
         ST_SQ_X: state_in = ST_SQ_Y;
         ST_SQ_Y: state_in = ST_ROOT;
         ST_ROOT: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_DIV_INIT;
               sel_in = DIV_X;
            end
         end
         ST_DIV_INIT: state_in = ST_DIV_STEP;
         ST_DIV_STEP: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               case (sel_ff)
                  DIV_X: begin
                     sel_in = DIV_Y;
                     state_in = ST_DIV_INIT;
                  end
                  DIV_Y: begin
                     sel_in = DIV_N;
                     state_in = ST_DIV_INIT;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl = '0;
      ctrl.sel = sel_ff;
      ctrl.cnt = cnt_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            ctrl.accept = req_valid;
         end
         ST_SQ_X: ctrl.sq_x = 1'b1;
         ST_SQ_Y: ctrl.sq_y = 1'b1;
         ST_ROOT: ctrl.root_step = 1'b1;
         ST_DIV_INIT: ctrl.div_init = 1'b1;
         ST_DIV_STEP: begin
            ctrl.div_step = 1'b1;
            ctrl.div_last = (cnt_ff == CNT_LAST);
         end
         ST_FINISH: ctrl.finish = rsp_free;
         default: ctrl = '0;
      endcase
   end
endmodule

// File: rtl/stick_dead_zone_and_button_edges.sv
// top level: stick normalization with circular dead zone and button edge flags
// depends on sdz_pkg, sdz_req_if, sdz_rsp_if, sdz_csr, sdz_trial_sub, sdz_ctrl
//
// usage
// - req takes one pad sample per word (connected, buttons, stick_x, stick_y, button_mask);
//   rsp returns one word per sample: dir_x, dir_y, magnitude_norm, is_down, pressed, released
// - valid/ready handshake on both channels; dead_zone sits at byte address 0 of the apb port;
//   the user must see that it is written only while the block is idle, as the block does not enforce it
// - a connected sample runs from accept to rsp valid through the squares of x and y on the
//   multiplier, 16 root steps and three 16-step divides (each after one setup step), all on
//   one shared trial subtractor, and last the load of the output register
// - a sample with connected low skips the arithmetic and goes straight to the output load,
//   repeating the last direction and magnitude
// - req.ready is high only while the sequencer is idle, so one sample is in flight and a
//   new one is accepted only once the sequencer is through with the last one
// - the result sits in an output register; the next sample is accepted while it waits, and
//   the sequencer holds its finished result until rsp is free
// - synchronous reset clears button history, held analog values and rsp.valid and sets
//   dead_zone to 7849
module stick_dead_zone_and_button_edges
   import sdz_pkg::*;
(
   input  logic clock,
   input  logic reset,
   sdz_req_if.sink req,
   sdz_rsp_if.source rsp,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic pready
);
   ctrl_type ctrl;
   logic [DZ_W-1:0] dead_zone;
   logic req_ready;
   logic rsp_free;

   logic conn_ff;
   logic [AXIS_W-1:0] cur_btn_ff, cur_btn_in;
   logic [AXIS_W-1:0] prev_btn_ff, prev_btn_in;
   logic [AXIS_W-1:0] mask_ff;
   logic [AXIS_W-1:0] ax_ff, ay_ff;
   logic x_neg_ff, y_neg_ff;
   logic [SQ_W-1:0] sq_ff, sq_in;
   logic [SQ_W-1:0] root_ff, root_in;
   logic [AXIS_W-1:0] rem_ff, rem_in;
   logic nb_ff, nb_in;
   logic [AXIS_W-1:0] qt_ff, qt_in;
   logic [AXIS_W-1:0] qx_ff, qy_ff, qn_ff;
   logic [AXIS_W-1:0] held_x_ff, held_x_in;
   logic [AXIS_W-1:0] held_y_ff, held_y_in;
   logic [AXIS_W-1:0] held_m_ff, held_m_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [AXIS_W-1:0] rsp_x_ff, rsp_y_ff, rsp_m_ff;
   logic rsp_down_ff, rsp_press_ff, rsp_rel_ff;

   logic [AXIS_W-1:0] abs_x, abs_y;
   logic [AXIS_W-1:0] mul_op;
   logic [SQ_W-1:0] mul_p;
   logic [4:0] shamt;
   logic [SQ_W-1:0] root_bit;
   logic [AXIS_W-1:0] mag;
   logic [DZ_W-1:0] mag_clip;
   logic above;
   logic [AXIS_W-1:0] num_n, den_n;
   logic [AXIS_W-1:0] div_num, div_den;
   logic [AXIS_W:0] trial;
   logic [SQ_W-1:0] op_a, op_b, sub_diff;
   logic sub_ge;
   logic [AXIS_W-1:0] q_fin;
   logic [AXIS_W-1:0] dir_x_new, dir_y_new, mag_new;
   logic [AXIS_W-1:0] cur_m, prev_m;

   sdz_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
      .dead_zone(dead_zone)
   );

   sdz_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req.valid), .req_connected(req.connected),
      .rsp_free(rsp_free), .req_ready(req_ready), .ctrl(ctrl)
   );

   sdz_trial_sub u_sub (
      .op_a(op_a), .op_b(op_b), .ge(sub_ge), .diff(sub_diff)
   );

   assign req.ready = req_ready;
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   // abs values and squares
   assign abs_x = req.stick_x[AXIS_W-1] ? AXIS_W'(-req.stick_x) : req.stick_x;
   assign abs_y = req.stick_y[AXIS_W-1] ? AXIS_W'(-req.stick_y) : req.stick_y;
   assign mul_op = ctrl.sq_x ? ax_ff : ay_ff;
   assign mul_p = mul_op * mul_op;

   always_comb begin
      sq_in = sq_ff;
      if (ctrl.sq_x) begin
         sq_in = mul_p;
      end else if (ctrl.sq_y) begin
         sq_in = sq_ff + mul_p;
      end else if (ctrl.root_step && sub_ge) begin
         sq_in = sub_diff;
      end
   end

   // root step operands
   assign shamt = {~ctrl.cnt, 1'b0};
   assign root_bit = SQ_W'(1) << shamt;

   always_comb begin
      root_in = root_ff;
      if (ctrl.sq_y) begin
         root_in = '0;
      end else if (ctrl.root_step) begin
         root_in = sub_ge ? ((root_ff >> 1) | root_bit) : (root_ff >> 1);
      end
   end

   // magnitude, clip and dead zone
   assign mag = root_ff[AXIS_W-1:0];
   assign mag_clip = (mag > {1'b0, FULL_SCALE}) ? FULL_SCALE : mag[DZ_W-1:0];
   assign above = mag_clip > dead_zone;
   assign num_n = above ? {1'b0, mag_clip - dead_zone} : '0;
   assign den_n = {1'b0, FULL_SCALE} - {1'b0, dead_zone};

   always_comb begin
      case (ctrl.sel)
         DIV_X: begin
            div_num = ax_ff;
            div_den = mag;
         end
         DIV_Y: begin
            div_num = ay_ff;
            div_den = mag;
         end
         default: begin
            div_num = num_n;
            div_den = den_n;
         end
      endcase
   end

   // divide steps
   assign trial = {rem_ff, nb_ff};
   assign op_a = ctrl.root_step ? sq_ff : {{(SQ_W-AXIS_W-1){1'b0}}, trial};
   assign op_b = ctrl.root_step ? (root_ff | root_bit) : {{(SQ_W-AXIS_W){1'b0}}, div_den};
   assign q_fin = {qt_ff[AXIS_W-2:0], sub_ge};

   always_comb begin
      rem_in = rem_ff;
      nb_in = nb_ff;
      qt_in = qt_ff;
      if (ctrl.div_init) begin
         rem_in = {1'b0, div_num[AXIS_W-1:1]};
         nb_in = div_num[0];
         qt_in = '0;
      end else if (ctrl.div_step) begin
         rem_in = sub_ge ? sub_diff[AXIS_W-1:0] : trial[AXIS_W-1:0];
         nb_in = 1'b0;
         qt_in = q_fin;
      end
   end

   // final selection
   always_comb begin
      if (mag == '0) begin
         dir_x_new = '0;
      end else if (x_neg_ff) begin
         dir_x_new = AXIS_W'(-qx_ff);
      end else begin
         dir_x_new = (qx_ff > {1'b0, FULL_SCALE}) ? {1'b0, FULL_SCALE} : qx_ff;
      end
      if (mag == '0) begin
         dir_y_new = '0;
      end else if (y_neg_ff) begin
         dir_y_new = AXIS_W'(-qy_ff);
      end else begin
         dir_y_new = (qy_ff > {1'b0, FULL_SCALE}) ? {1'b0, FULL_SCALE} : qy_ff;
      end
      mag_new = above ? qn_ff : '0;
   end

   assign held_x_in = (ctrl.finish && conn_ff) ? dir_x_new : held_x_ff;
   assign held_y_in = (ctrl.finish && conn_ff) ? dir_y_new : held_y_ff;
   assign held_m_in = (ctrl.finish && conn_ff) ? mag_new : held_m_ff;

   assign prev_btn_in = ctrl.accept ? cur_btn_ff : prev_btn_ff;
   assign cur_btn_in = ctrl.accept ? (req.connected ? req.buttons : '0) : cur_btn_ff;
   assign cur_m = cur_btn_ff & mask_ff;
   assign prev_m = prev_btn_ff & mask_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_btn_ff <= '0;
         prev_btn_ff <= '0;
         held_x_ff <= '0;
         held_y_ff <= '0;
         held_m_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_btn_ff <= cur_btn_in;
         prev_btn_ff <= prev_btn_in;
         held_x_ff <= held_x_in;
         held_y_ff <= held_y_in;
         held_m_ff <= held_m_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (ctrl.accept) begin
         conn_ff <= req.connected;
         mask_ff <= req.button_mask;
         ax_ff <= abs_x;
         ay_ff <= abs_y;
         x_neg_ff <= req.stick_x[AXIS_W-1];
         y_neg_ff <= req.stick_y[AXIS_W-1];
      end
      sq_ff <= sq_in;
      root_ff <= root_in;
      rem_ff <= rem_in;
      nb_ff <= nb_in;
      qt_ff <= qt_in;
      if (ctrl.div_last) begin
         case (ctrl.sel)
            DIV_X: qx_ff <= q_fin;
            DIV_Y: qy_ff <= q_fin;
            default: qn_ff <= q_fin;
         endcase
      end
      if (ctrl.finish) begin
         rsp_x_ff <= held_x_in;
         rsp_y_ff <= held_y_in;
         rsp_m_ff <= held_m_in;
         rsp_down_ff <= (cur_m == mask_ff);
         rsp_press_ff <= (prev_m == '0) && (cur_m != '0);
         rsp_rel_ff <= (prev_m != '0) && (cur_m == '0);
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.dir_x = rsp_x_ff;
   assign rsp.dir_y = rsp_y_ff;
   assign rsp.magnitude_norm = rsp_m_ff;
   assign rsp.is_down = rsp_down_ff;
   assign rsp.pressed = rsp_press_ff;
   assign rsp.released = rsp_rel_ff;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("sequencer ready right after accepting a word");

   a_mag_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.div_init |-> (root_ff[SQ_W-1:AXIS_W] == '0) && (mag <= MAG_MAX))
      else $error("root out of range");

   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (ctrl.div_step && (div_den != '0)) |-> (rem_ff < div_den))
      else $error("partial remainder not below divisor");

   a_quot_range: assert property (@(posedge clock) disable iff (reset)
      (ctrl.div_last && (div_den != '0)) |-> (q_fin <= Q_MAX))
      else $error("quotient above one");
endmodule

// File: bench/sdz_checker.sv
`timescale 1ns / 1ps
// result checker for stick_dead_zone_and_button_edges: predicts each result word from
// accepted sample words and dead zone writes, and compares it with the block's output
// depends on sdz_pkg, sdz_req_if and sdz_rsp_if
module sdz_checker
   import sdz_pkg::*;
(
   input  logic clock,
   input  logic reset,
   sdz_req_if req,
   sdz_rsp_if rsp,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   input  logic pready,
   output int mismatches,
   output int awaiting,
   output int checked
);

   typedef struct packed {
      logic [AXIS_W-1:0] dir_x;
      logic [AXIS_W-1:0] dir_y;
      logic [AXIS_W-1:0] magnitude_norm;
      logic is_down;
      logic pressed;
      logic released;
   } stick_word_type;

   stick_word_type expected_words[$];
   logic [DZ_W-1:0] radius = DZ_RESET;
   logic [AXIS_W-1:0] buttons_now = '0;
   logic [AXIS_W-1:0] buttons_last = '0;
   logic [AXIS_W-1:0] hold_x = '0;
   logic [AXIS_W-1:0] hold_y = '0;
   logic [AXIS_W-1:0] hold_mag = '0;
   int errors = 0;
   int seen = 0;

   function automatic logic [AXIS_W-1:0] stick_root(input logic [SQ_W-1:0] sum);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = AXIS_W - 1; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= {32'd0, sum}) root = trial;
      end
      return root[AXIS_W-1:0];
   endfunction

   function automatic logic [AXIS_W-1:0] unit_axis(input logic signed [AXIS_W-1:0] axis,
                                                   input logic [AXIS_W-1:0] mag);
      longint span;
      longint q;
      span = (axis < 0) ? -longint'(axis) : longint'(axis);
      q = (span * 32768) / longint'(mag);
      if (axis < 0) begin
         if (q > 32768) q = 32768;
         q = -q;
      end else if (q > 32767) begin
         q = 32767;
      end
      return q[AXIS_W-1:0];
   endfunction

   function automatic stick_word_type normalize_sample(input logic conn,
                                                       input logic [AXIS_W-1:0] btn,
                                                       input logic signed [AXIS_W-1:0] sx,
                                                       input logic signed [AXIS_W-1:0] sy,
                                                       input logic [AXIS_W-1:0] mask);
      stick_word_type w;
      longint sq;
      longint clipped;
      logic [AXIS_W-1:0] mag;
      buttons_last = buttons_now;
      buttons_now = conn ? btn : '0;
      if (conn) begin
         sq = longint'(sx) * longint'(sx) + longint'(sy) * longint'(sy);
         mag = stick_root(sq[SQ_W-1:0]);
         if (mag == 0) begin
            hold_x = '0;
            hold_y = '0;
         end else begin
            hold_x = unit_axis(sx, mag);
            hold_y = unit_axis(sy, mag);
         end
         hold_mag = '0;
         // dead zone test on the exact sum of squares, rescale on the clipped root
         if (radius < FULL_SCALE && sq > longint'(radius) * longint'(radius)) begin
            clipped = longint'(mag);
            if (clipped > longint'(FULL_SCALE)) clipped = longint'(FULL_SCALE);
            if (clipped > longint'(radius))
               hold_mag = AXIS_W'(((clipped - longint'(radius)) * 32768) /
                                  (longint'(FULL_SCALE) - longint'(radius)));
         end
      end
      w.dir_x = hold_x;
      w.dir_y = hold_y;
      w.magnitude_norm = hold_mag;
      w.is_down = ((buttons_now & mask) == mask);
      w.pressed = ((buttons_last & mask) == 0) && ((buttons_now & mask) != 0);
      w.released = ((buttons_last & mask) != 0) && ((buttons_now & mask) == 0);
      return w;
   endfunction

   always @(posedge clock) begin : watch
      stick_word_type got;
      stick_word_type want;
      if (reset) begin
         expected_words.delete();
         radius = DZ_RESET;
         buttons_now = '0;
         buttons_last = '0;
         hold_x = '0;
         hold_y = '0;
         hold_mag = '0;
      end else begin
         if (psel && penable && pwrite && pready && paddr == {REG_DEAD_ZONE, 2'b00})
            radius = pwdata[DZ_W-1:0];
         if (rsp.valid && rsp.ready) begin
            got = '{rsp.dir_x, rsp.dir_y, rsp.magnitude_norm,
                    rsp.is_down, rsp.pressed, rsp.released};
            if (expected_words.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: result word with nothing expected", $realtime);
            end else begin
               want = expected_words.pop_front();
               seen++;
               if (got != want) begin
                  errors++;
                  if (errors <= 10) begin
                     $display("%0t: word %0d expected dir %0d,%0d mag %0d down %b press %b rel %b",
                              $realtime, seen, $signed(want.dir_x), $signed(want.dir_y),
                              want.magnitude_norm, want.is_down, want.pressed, want.released);
                     $display("%0t: word %0d actual   dir %0d,%0d mag %0d down %b press %b rel %b",
                              $realtime, seen, $signed(got.dir_x), $signed(got.dir_y),
                              got.magnitude_norm, got.is_down, got.pressed, got.released);
                  end
               end
            end
         end
         if (req.valid && req.ready)
            expected_words.push_back(normalize_sample(req.connected, req.buttons, req.stick_x,
                                                      req.stick_y, req.button_mask));
      end
      awaiting <= expected_words.size();
      mismatches <= errors;
      checked <= seen;
   end

endmodule

// File: bench/tb_stick_dead_zone_and_button_edges.sv
`timescale 1ns / 1ps
// top of the bench for stick_dead_zone_and_button_edges: drives pad samples, dead zone
// writes and result back-pressure, and reports the verdict from sdz_checker
// depends on sdz_pkg, sdz_req_if, sdz_rsp_if, sdz_checker and the block itself
module tb_stick_dead_zone_and_button_edges;
   import sdz_pkg::*;

   localparam int PHASES = 8;
   localparam int WORDS_PER_PHASE = 243;
   localparam int HOLD_CYCLES = 400;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 100;
   localparam logic [CSR_AW-1:0] DEAD_ZONE_ADDR = {REG_DEAD_ZONE, 2'b00};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic pready;

   int mismatches;
   int awaiting;
   int checked;
   bit calm = 1'b0;
   int hold_asks = 0;
   int holds_done = 0;
   int idle_cycles = 0;
   int sample_count = 0;
   int absent_count = 0;
   int setting_count = 0;
   logic [AXIS_W-1:0] last_buttons = '0;
   logic [DZ_W-1:0] radius_now = DZ_RESET;

   sdz_req_if req_bus ();
   sdz_rsp_if rsp_bus ();

   always #5 clock = ~clock;

   stick_dead_zone_and_button_edges DUT (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .rsp     (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   sdz_checker check_unit (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .pready     (pready),
      .mismatches (mismatches),
      .awaiting   (awaiting),
      .checked    (checked)
   );

   // result side: random stalls, a calm stretch, and long hold-offs on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asks != holds_done) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(0, 99) >= 21);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) || psel)
         idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   task automatic offer_sample(input logic conn, input logic [AXIS_W-1:0] btn, input int sx,
                               input int sy, input logic [AXIS_W-1:0] mask);
      while (!calm && $urandom_range(0, 99) < 21) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.connected <= conn;
      req_bus.buttons <= btn;
      req_bus.stick_x <= AXIS_W'(sx);
      req_bus.stick_y <= AXIS_W'(sy);
      req_bus.button_mask <= mask;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sample_count++;
      if (!conn) absent_count++;
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (awaiting != 0);
   endtask

   task automatic write_dead_zone(input logic [DZ_W-1:0] value);
      settle();
      repeat (4) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= DEAD_ZONE_ADDR;
      pwdata <= CSR_DW'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      radius_now = value;
      setting_count++;
   endtask

   task automatic offer_random_sample();
      int kind;
      int r;
      int sx;
      int sy;
      int swap;
      logic conn;
      logic [AXIS_W-1:0] btn;
      logic [AXIS_W-1:0] mask;
      conn = ($urandom_range(0, 9) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
         sx = int'($urandom_range(0, 65535)) - 32768;
         sy = int'($urandom_range(0, 65535)) - 32768;
      end else if (kind < 70) begin
         // around the dead zone circle
         r = int'(radius_now);
         sx = int'($urandom_range(0, 2 * r + 8)) - (r + 4);
         sy = int'($urandom_range(0, 6)) - 3;
      end else if (kind < 80) begin
         sx = int'($urandom_range(0, 8)) - 4;
         sy = int'($urandom_range(0, 8)) - 4;
      end else if (kind < 90) begin
         sx = (kind % 3 == 0) ? -32768 : (kind % 3 == 1) ? 32767 : 0;
         sy = int'($urandom_range(0, 2)) * 32767 - 32768 + int'($urandom_range(0, 1));
      end else begin
         sx = 32767 - int'($urandom_range(0, 300));
         sy = int'($urandom_range(0, 600)) - 300;
      end
      if (sx > 32767) sx = 32767;
      if (sx < -32768) sx = -32768;
      swap = $urandom_range(0, 1);
      if (swap != 0) begin
         r = sx;
         sx = sy;
         sy = r;
      end
      case ($urandom_range(0, 3))
         0: btn = last_buttons ^ (16'd1 << $urandom_range(0, 15));
         1: btn = last_buttons;
         2: btn = '0;
         default: btn = AXIS_W'($urandom());
      endcase
      case ($urandom_range(0, 9))
         0: mask = '0;
         1, 2, 3, 4: mask = 16'd1 << $urandom_range(0, 15);
         5, 6, 7: mask = AXIS_W'($urandom());
         default: mask = AXIS_W'($urandom()) & (btn | last_buttons);
      endcase
      offer_sample(conn, btn, sx, sy, mask);
      last_buttons = conn ? btn : '0;
   endtask

   initial begin
      req_bus.valid <= 1'b0;
      req_bus.connected <= 1'b0;
      req_bus.buttons <= '0;
      req_bus.stick_x <= '0;
      req_bus.stick_y <= '0;
      req_bus.button_mask <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // absent pad right after reset, then zero stick and empty mask
      offer_sample(1'b0, 16'hFFFF, 32767, 32767, 16'h0001);
      offer_sample(1'b1, 16'h0000, 0, 0, 16'h0000);
      offer_sample(1'b1, 16'h0001, 32767, 0, 16'h0001);
      offer_sample(1'b1, 16'h0001, -32768, 0, 16'h0001);
      offer_sample(1'b1, 16'h0000, -32768, -32768, 16'h0001);
      offer_sample(1'b1, 16'hFFFF, 32767, 32767, 16'hFFFF);
      offer_sample(1'b1, 16'hFFFF, 0, -32768, 16'h8000);
      // on the dead zone edge, and root equal to the radius with the sum above it
      offer_sample(1'b1, 16'h8000, 7849, 0, 16'h8000);
      offer_sample(1'b1, 16'h8000, 7849, 1, 16'h0000);
      offer_sample(1'b1, 16'h7FFF, 0, -7850, 16'h8001);
      offer_sample(1'b1, 16'h0000, 5550, 5550, 16'h7FFF);
      offer_sample(1'b1, 16'h0000, 5551, 5550, 16'h7FFF);
      // unit magnitude saturates the direction
      offer_sample(1'b1, 16'h0000, 1, 0, 16'h0000);
      offer_sample(1'b1, 16'h0000, -1, 0, 16'h0000);
      offer_sample(1'b1, 16'h0000, 1, -1, 16'h0000);
      offer_sample(1'b1, 16'hA5A5, 3, 4, 16'h0005);
      offer_sample(1'b0, 16'h5A5A, -32768, 32767, 16'h0005);
      offer_sample(1'b0, 16'h5A5A, 0, 0, 16'h0000);
      offer_sample(1'b1, 16'h5A5A, -20000, 25000, 16'h5A5A);
      offer_sample(1'b1, 16'h5A5A, 32767, -32768, 16'hFFFF);
      last_buttons = 16'h5A5A;

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: ;
            1: write_dead_zone('0);
            2: write_dead_zone(FULL_SCALE);
            3: write_dead_zone(FULL_SCALE - 15'd1);
            4: write_dead_zone(15'd1);
            7: write_dead_zone(DZ_RESET);
            default: write_dead_zone(DZ_W'($urandom_range(0, 32766)));
         endcase
         calm <= (p == 3);
         for (int i = 0; i < WORDS_PER_PHASE; i++) begin
            if (p == 2 && i == 50) hold_asks <= hold_asks + 1;
            offer_random_sample();
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d samples (%0d with the pad absent) under %0d dead zone writes plus reset value",
               sample_count, absent_count, setting_count);
      $display("%0d result words compared, %0d mismatches", checked, mismatches);
      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
